// ----- sv/sdd_pkg.sv -----
// Shared constants, types and hash helper of the stream duplicate detector.
package sdd_pkg;

  localparam int unsigned SET_CAPACITY = 1024;
  // Open-addressed table at twice the capacity, so a probe always meets a free slot.
  localparam int unsigned TABLE_DEPTH  = 2 * SET_CAPACITY;
  localparam int unsigned IDX_W        = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W        = $clog2(SET_CAPACITY + 1);
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned EPOCH_W      = 8;
  localparam int unsigned ENTRY_W      = EPOCH_W + VALUE_W;

  // Epoch zero marks a slot that the sweep has cleared; live lists use the others.
  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  localparam logic [VALUE_W-1:0] HASH_MULT = 32'h9E37_79B1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HASH  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  // Multiplicative hash: the top bits of the low product word.
  function automatic logic [IDX_W-1:0] hash_index(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] prod;
    prod = v * HASH_MULT;
    return prod[VALUE_W-1 -: IDX_W];
  endfunction

endpackage

// ----- sv/stream_duplicate_detector_unit.sv -----
// Top level of the stream duplicate detector: hashed set in one RAM, probed per item.
// Flow: ST_IDLE registers the item, ST_HASH reads its home slot, ST_CHECK compares it and
// loads the result register, repeating on each collision (linear probe loop over the single
// read port). No new item is taken before the result loads; on stall it waits in ST_EMIT.
// Reset (rst, synchronous, active high) starts a sweep of all TABLE_DEPTH (2048) slots that
// clears the table; the same sweep runs after every 255th list when the epoch wraps.
module stream_duplicate_detector_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  input  logic               list_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_repeat,
  output logic               duplicate_seen,
  output logic               result_last,
  output logic               store_full
);

  sdd_pkg::state_t state;

  logic [sdd_pkg::VALUE_W-1:0] item_value;
  logic                        item_last;
  logic [sdd_pkg::IDX_W-1:0]   probe_addr;
  logic [sdd_pkg::IDX_W-1:0]   clr_idx;
  logic [sdd_pkg::EPOCH_W-1:0] epoch;
  logic [sdd_pkg::EPOCH_W-1:0] epoch_next;
  logic [sdd_pkg::CNT_W-1:0]   count;
  logic                        repeat_flag;
  logic                        full_flag;
  logic                        pend_repeat;
  logic                        pend_dup;
  logic                        pend_last;
  logic                        pend_full;

  logic                        ram_we;
  logic [sdd_pkg::IDX_W-1:0]   ram_waddr;
  logic [sdd_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [sdd_pkg::IDX_W-1:0]   ram_raddr;
  logic [sdd_pkg::ENTRY_W-1:0] ram_rdata;

  logic                        slot_live;
  logic                        hit;
  logic                        resolved;
  logic                        room;
  logic                        insert;
  logic                        res_dup;
  logic                        res_full;
  logic                        out_free;
  logic                        out_load;

  sdd_ram #(
    .WIDTH(sdd_pkg::ENTRY_W),
    .DEPTH(sdd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall = (state != sdd_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign slot_live = (ram_rdata[sdd_pkg::ENTRY_W-1 -: sdd_pkg::EPOCH_W] == epoch);
  assign hit       = slot_live && (ram_rdata[sdd_pkg::VALUE_W-1:0] == item_value);
  assign resolved  = !slot_live || hit;
  assign room      = (count < sdd_pkg::CNT_W'(sdd_pkg::SET_CAPACITY));
  assign insert    = (state == sdd_pkg::ST_CHECK) && resolved && !hit && room;
  assign res_dup   = repeat_flag || hit;
  assign res_full  = full_flag || (!hit && !room);

  assign epoch_next = item_last ? epoch + sdd_pkg::EPOCH_W'(1) : epoch;

  assign out_load = ((state == sdd_pkg::ST_CHECK) && resolved && out_free) ||
                    ((state == sdd_pkg::ST_EMIT) && out_free);

  // Read port: home slot after hashing, then the next slot on each collision.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = probe_addr + sdd_pkg::IDX_W'(1);
    case (state)
      sdd_pkg::ST_HASH: begin
        ram_re    = 1'b1;
        ram_raddr = sdd_pkg::hash_index(item_value);
      end
      sdd_pkg::ST_CHECK: begin
        ram_re = !resolved;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state == sdd_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = insert;
      ram_waddr = probe_addr;
      ram_wdata = {epoch, item_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sdd_pkg::ST_CLEAR;
      clr_idx     <= '0;
      epoch       <= sdd_pkg::EPOCH_SWEPT;
      count       <= '0;
      repeat_flag <= 1'b0;
      full_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ram_re) begin
        probe_addr <= ram_raddr;
      end

      case (state)
        sdd_pkg::ST_IDLE: begin
          if (in_valid) begin
            item_value <= $unsigned(value);
            item_last  <= list_end;
            state      <= sdd_pkg::ST_HASH;
          end
        end

        sdd_pkg::ST_HASH: begin
          state <= sdd_pkg::ST_CHECK;
        end

        sdd_pkg::ST_CHECK: begin
          if (resolved) begin
            // Flags and count drop at the list end; the epoch moves on so old slots go stale.
            if (item_last) begin
              repeat_flag <= 1'b0;
              full_flag   <= 1'b0;
              count       <= '0;
            end else begin
              repeat_flag <= res_dup;
              full_flag   <= res_full;
              count       <= count + sdd_pkg::CNT_W'(insert);
            end
            epoch       <= epoch_next;
            pend_repeat <= hit;
            pend_dup    <= res_dup;
            pend_last   <= item_last;
            pend_full   <= res_full;
            if (out_free) begin
              is_repeat      <= hit;
              duplicate_seen <= res_dup;
              result_last    <= item_last;
              store_full     <= res_full;
              state          <= (epoch_next == sdd_pkg::EPOCH_SWEPT) ?
                                sdd_pkg::ST_CLEAR : sdd_pkg::ST_IDLE;
            end else begin
              state <= sdd_pkg::ST_EMIT;
            end
          end
        end

        sdd_pkg::ST_EMIT: begin
          if (out_free) begin
            is_repeat      <= pend_repeat;
            duplicate_seen <= pend_dup;
            result_last    <= pend_last;
            store_full     <= pend_full;
            state          <= (epoch == sdd_pkg::EPOCH_SWEPT) ?
                              sdd_pkg::ST_CLEAR : sdd_pkg::ST_IDLE;
          end
        end

        sdd_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + sdd_pkg::IDX_W'(1);
          if (clr_idx == sdd_pkg::IDX_W'(sdd_pkg::TABLE_DEPTH - 1)) begin
            epoch <= sdd_pkg::EPOCH_FIRST;
            state <= sdd_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= sdd_pkg::ST_CLEAR;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sdd_pkg::CNT_W'(sdd_pkg::SET_CAPACITY))
    else $error("set count exceeds capacity");

  a_live_epoch: assert property (@(posedge clk) disable iff (rst)
    (state == sdd_pkg::ST_CHECK) |-> (epoch != sdd_pkg::EPOCH_SWEPT))
    else $error("probe against swept epoch");

  a_list_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == sdd_pkg::ST_CHECK) && resolved && item_last) |=>
    ((count == '0) && !repeat_flag && !full_flag))
    else $error("list state not cleared after final item");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");

  a_no_write_on_lookup: assert property (@(posedge clk) disable iff (rst)
    ((state == sdd_pkg::ST_HASH) || (state == sdd_pkg::ST_IDLE)) |-> !ram_we)
    else $error("table written outside resolve or sweep");

endmodule

// ----- sv/sdd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sdd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
